FILE: rtl/core/adts_pkg.sv
// Shared types and constants for the ADTS stream deframer.
package adts_pkg;

  // Error codes reported on the result channel
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_SYNC  = 3'd1;
  localparam logic [2:0] ERR_BAD_LAYER = 3'd2;
  localparam logic [2:0] ERR_SHORT_LEN = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  // Header constants
  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [7:0] SYNC_MASK   = 8'hF0;
  localparam logic [3:0] HDR_LEN_STD = 4'd7;  // no CRC bytes
  localparam logic [3:0] HDR_LEN_CRC = 4'd9;  // two CRC bytes follow

  localparam int unsigned LEN_W = 13;

  // Deframer state carried from byte to byte
  typedef struct packed {
    logic [3:0]       hdr_pos;
    logic             crc_present;
    logic [LEN_W-1:0] frame_len;
    logic [LEN_W-1:0] remaining;
    logic             in_payload;
    logic             discarding;
  } deframe_state_t;

  // One result transaction
  typedef struct packed {
    logic             byte_valid;
    logic [7:0]       payload_byte;
    logic             frame_end;
    logic [LEN_W-1:0] frame_payload_length;
    logic             buffer_end;
    logic [2:0]       error_code;
  } deframe_result_t;

endpackage

FILE: rtl/core/adts_in_if.sv
// Byte input channel: valid/ready handshake with one buffer byte.
interface adts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_last;

  modport source (output valid, output data_byte, output buffer_last, input ready);
  modport sink   (input valid, input data_byte, input buffer_last, output ready);
endinterface

FILE: rtl/core/adts_out_if.sv
// Result channel: valid/ready handshake with one deframer result.
interface adts_out_if;
  logic                        valid;
  logic                        ready;
  logic                        byte_valid;
  logic [7:0]                  payload_byte;
  logic                        frame_end;
  logic [adts_pkg::LEN_W-1:0]  frame_payload_length;
  logic                        buffer_end;
  logic [2:0]                  error_code;

  modport source (output valid, output byte_valid, output payload_byte, output frame_end,
                  output frame_payload_length, output buffer_end, output error_code,
                  input ready);
  modport sink   (input valid, input byte_valid, input payload_byte, input frame_end,
                  input frame_payload_length, input buffer_end, input error_code,
                  output ready);
endinterface

FILE: rtl/core/adts_stream_deframer.sv
// ADTS stream deframer top level: input register, deframing step, result register.
//
// Accepts an ADTS-framed AAC buffer one byte per transaction, with buffer_last set on the
// final byte, and returns the raw payload bytes with each frame's end marked by its payload
// length. Headers (7 bytes, or 9 with CRC) are stripped; CRC bytes are skipped unchecked.
// A byte yields at most one result transaction: payload bytes, frame completions (an empty
// frame completes on its last header byte), errors and the buffer's last byte produce one;
// other header bytes produce none. On a bad sync, nonzero layer, frame length below header
// size, or a buffer ending mid-frame, one error transaction is sent and the rest of the
// buffer is dropped silently until its last byte, which yields a plain buffer_end result.
// State returns to reset after every buffer's last byte.
// Throughput is one byte per clock: the deframer state updates combinationally per byte,
// so an input transaction can be taken every cycle while the result register is free or
// being drained. A result passes through the input register, then the result register.
// Back-pressure from the result side only stalls bytes that produce a result.
module adts_stream_deframer (
  input  logic          clk_i,
  input  logic          rst_ni,
  adts_in_if.sink       data_in_i,
  adts_out_if.source    data_out_o
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // deframer state
  adts_pkg::deframe_state_t  state_q, state_d;
  logic                      emit;
  adts_pkg::deframe_result_t step_res;

  // result register
  logic                      out_valid_q, out_valid_d;
  adts_pkg::deframe_result_t out_res_q;

  logic out_free;
  logic advance;
  logic in_take;

  adts_step u_step (
    .state_i       (state_q),
    .data_byte_i   (in_byte_q),
    .buffer_last_i (in_last_q),
    .state_o       (state_d),
    .emit_o        (emit),
    .result_o      (step_res)
  );

  // result register can take a new transaction when empty or being drained
  assign out_free = !out_valid_q || data_out_o.ready;
  // the held byte is processed unless it needs a result slot that is still occupied
  assign advance  = in_valid_q && (!emit || out_free);

  assign data_in_i.ready = !in_valid_q || advance;
  assign in_take         = data_in_i.valid && data_in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (data_in_i.ready) in_valid_d = data_in_i.valid;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && emit) out_valid_d = 1'b1;
    else if (data_out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) state_q <= state_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= data_in_i.data_byte;
      in_last_q <= data_in_i.buffer_last;
    end
    if (advance && emit) out_res_q <= step_res;
  end

  assign data_out_o.valid                = out_valid_q;
  assign data_out_o.byte_valid           = out_res_q.byte_valid;
  assign data_out_o.payload_byte         = out_res_q.payload_byte;
  assign data_out_o.frame_end            = out_res_q.frame_end;
  assign data_out_o.frame_payload_length = out_res_q.frame_payload_length;
  assign data_out_o.buffer_end           = out_res_q.buffer_end;
  assign data_out_o.error_code           = out_res_q.error_code;

endmodule

FILE: rtl/core/adts_step.sv
// Per-byte deframing logic: next state and optional result for one byte.
module adts_step (
  input  adts_pkg::deframe_state_t  state_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      buffer_last_i,
  output adts_pkg::deframe_state_t  state_o,
  output logic                      emit_o,
  output adts_pkg::deframe_result_t result_o
);

  // Header byte positions
  localparam logic [3:0] HP_SYNC0 = 4'd0;
  localparam logic [3:0] HP_SYNC1 = 4'd1;
  localparam logic [3:0] HP_BYTE2 = 4'd2;
  localparam logic [3:0] HP_LEN_HI = 4'd3;
  localparam logic [3:0] HP_LEN_MID = 4'd4;
  localparam logic [3:0] HP_LEN_LO = 4'd5;
  localparam logic [3:0] HP_TAIL = 4'd6;

  logic [3:0]                 hdr_len;
  logic [4:0]                 pos_plus1;
  logic                       done_hdr;
  logic                       completes;
  logic [adts_pkg::LEN_W-1:0] hdr_len_ext;
  logic [adts_pkg::LEN_W-1:0] pay_len;
  logic [adts_pkg::LEN_W-1:0] len_lo;
  logic [2:0]                 err;

  assign hdr_len     = state_i.crc_present ? adts_pkg::HDR_LEN_CRC : adts_pkg::HDR_LEN_STD;
  assign hdr_len_ext = {{(adts_pkg::LEN_W-4){1'b0}}, hdr_len};
  assign pos_plus1   = {1'b0, state_i.hdr_pos} + 5'd1;
  assign done_hdr    = (state_i.hdr_pos >= HP_TAIL) && (pos_plus1 >= {1'b0, hdr_len});
  assign completes   = done_hdr && (state_i.frame_len == hdr_len_ext);
  assign pay_len     = state_i.frame_len - hdr_len_ext;
  assign len_lo      = {state_i.frame_len[adts_pkg::LEN_W-1:3], data_byte_i[7:5]};

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    emit_o   = 1'b0;
    err      = adts_pkg::ERR_NONE;

    if (state_i.discarding) begin
      // drop everything until the buffer closes
      if (buffer_last_i) begin
        state_o             = '0;
        emit_o              = 1'b1;
        result_o.buffer_end = 1'b1;
      end
    end else begin
      if (state_i.in_payload) begin
        if (state_i.remaining <= 13'd1) begin
          result_o.byte_valid           = 1'b1;
          result_o.payload_byte         = data_byte_i;
          result_o.frame_end            = 1'b1;
          result_o.frame_payload_length = pay_len;
          state_o.in_payload            = 1'b0;
          state_o.remaining             = '0;
          state_o.hdr_pos               = HP_SYNC0;
          emit_o                        = 1'b1;
        end else if (buffer_last_i) begin
          err = adts_pkg::ERR_TRUNCATED;
        end else begin
          result_o.byte_valid   = 1'b1;
          result_o.payload_byte = data_byte_i;
          state_o.remaining     = state_i.remaining - 13'd1;
          emit_o                = 1'b1;
        end
      end else if (buffer_last_i && !completes) begin
        err = adts_pkg::ERR_TRUNCATED;
      end else begin
        case (state_i.hdr_pos)
          HP_SYNC0: begin
            if (data_byte_i != adts_pkg::SYNC_BYTE) err = adts_pkg::ERR_BAD_SYNC;
            else state_o.hdr_pos = HP_SYNC1;
          end
          HP_SYNC1: begin
            if ((data_byte_i & adts_pkg::SYNC_MASK) != adts_pkg::SYNC_MASK) begin
              err = adts_pkg::ERR_BAD_SYNC;
            end else if (data_byte_i[2:1] != 2'b00) begin
              err = adts_pkg::ERR_BAD_LAYER;
            end else begin
              state_o.crc_present = ~data_byte_i[0];
              state_o.hdr_pos     = HP_BYTE2;
            end
          end
          HP_BYTE2: state_o.hdr_pos = HP_LEN_HI;
          HP_LEN_HI: begin
            state_o.frame_len = {data_byte_i[1:0], {(adts_pkg::LEN_W-2){1'b0}}};
            state_o.hdr_pos   = HP_LEN_MID;
          end
          HP_LEN_MID: begin
            state_o.frame_len = {state_i.frame_len[adts_pkg::LEN_W-1:11], data_byte_i, 3'b000};
            state_o.hdr_pos   = HP_LEN_LO;
          end
          HP_LEN_LO: begin
            state_o.frame_len = len_lo;
            if (len_lo < hdr_len_ext) err = adts_pkg::ERR_SHORT_LEN;
            else state_o.hdr_pos = HP_TAIL;
          end
          default: begin
            if (!done_hdr) begin
              state_o.hdr_pos = pos_plus1[3:0];
            end else begin
              state_o.hdr_pos = HP_SYNC0;
              if (completes) begin
                result_o.frame_end = 1'b1;
                emit_o             = 1'b1;
              end else begin
                state_o.in_payload = 1'b1;
                state_o.remaining  = pay_len;
              end
            end
          end
        endcase
      end

      if (err != adts_pkg::ERR_NONE) begin
        state_o             = '0;
        state_o.discarding  = ~buffer_last_i;
        result_o            = '0;
        result_o.buffer_end = buffer_last_i;
        result_o.error_code = err;
        emit_o              = 1'b1;
      end else if (buffer_last_i) begin
        state_o             = '0;
        result_o.buffer_end = 1'b1;
        emit_o              = 1'b1;
      end
    end
  end

endmodule
